[hdl/stream_find_replace_first_defines.svh]
// assertion macros for the streaming find and replace block
`ifndef STREAM_FIND_REPLACE_FIRST_DEFINES_SVH
`define STREAM_FIND_REPLACE_FIRST_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfr_pkg.sv]
// shared types and constants of the streaming find and replace block
package sfr_pkg;

  localparam int unsigned CharW          = 8;
  localparam int unsigned CfgW           = 64;
  localparam int unsigned LenW           = 4;
  localparam int unsigned PatternMaxDef  = 8;
  localparam int unsigned ReplaceMaxDef  = 8;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             present;
    logic             last;
  } res_t;

endpackage

[hdl/sfr_cell.sv]
// one window cell: holds a character, takes an insert, shifts toward the head
module sfr_cell (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         shift_i,
  input  logic [sfr_pkg::CharW-1:0]    char_i,
  input  logic [sfr_pkg::CharW-1:0]    right_i,
  input  logic [sfr_pkg::CharW-1:0]    pat_i,
  output logic [sfr_pkg::CharW-1:0]    post_o,
  output logic                         eq_o
);

  logic [sfr_pkg::CharW-1:0] char_q;
  logic [sfr_pkg::CharW-1:0] char_d;

  // value after this cycle's insert, seen by the left neighbor
  assign post_o = load_i ? char_i : char_q;
  assign eq_o   = (post_o == pat_i);
  assign char_d = shift_i ? right_i : post_o;

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

[hdl/sfr_out_skid.sv]
// output register with a skid stage for the result channel
module sfr_out_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sfr_pkg::res_t out_data_o
);

  logic          out_v_q;
  logic          skid_v_q;
  sfr_pkg::res_t out_q;
  sfr_pkg::res_t skid_q;
  logic          take;

  assign take        = out_v_q && !out_stall_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_v_q || take) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end else if (take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

endmodule

[hdl/stream_find_replace_first.sv]
// streaming find and replace of the first match, top level
//
// Text enters on the input channel one character per transfer, end_of_text_i
// high on the final one. Edited text leaves on the output channel; an
// end-only marker (char_present_o low) closes a text whose tail was deleted.
// Config registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the block is idle (not enforced here).
// A row of PATTERN_MAX cells holds the window; every cell compares its
// character with its pattern byte, and on a drop every cell takes its right
// neighbor. A character that yields at most one result does not hold the input,
// so plain text streams at one transfer per cycle while the receiver does not
// stall; results are registered in the output register. While a replacement of
// R characters or an end-of-text flush of F window characters is pushed, one
// character at a time, the input is stalled; the one output port is the limit.
// Reset empties the window, clears the match flag and sets the registers to
// their defaults (pattern length 1). When the receiver stalls, results wait
// in the output register and a skid stage, and the input stalls once the
// skid stage is occupied.
`include "stream_find_replace_first_defines.svh"

module stream_find_replace_first #(
  parameter int unsigned PATTERN_MAX = sfr_pkg::PatternMaxDef,
  parameter int unsigned REPLACE_MAX = sfr_pkg::ReplaceMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [sfr_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sfr_pkg::CharW-1:0]  text_char_i,
  input  logic                       end_of_text_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sfr_pkg::CharW-1:0]  out_char_o,
  output logic                       char_present_o,
  output logic                       end_of_output_o
);

  localparam int unsigned FW  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
  localparam int unsigned LW  = sfr_pkg::LenW;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPL,
    ST_FLUSH
  } state_e;

  // config registers
  logic [sfr_pkg::CfgW-1:0] pattern_bytes_q;
  logic [LW-1:0]            pattern_length_q;
  logic [sfr_pkg::CfgW-1:0] replacement_bytes_q;
  logic [LW-1:0]            replacement_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q      <= '0;
      pattern_length_q     <= LW'(1);
      replacement_bytes_q  <= '0;
      replacement_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (sfr_pkg::cfg_reg_e'(cfg_idx_i))
        sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data_i;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data_i[LW-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data_i;
        sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data_i[LW-1:0];
      endcase
    end
  end

  logic [LW-1:0] plen;
  logic [LW-1:0] rlen;

  always_comb begin
    if (pattern_length_q == '0) begin
      plen = LW'(1);
    end else if (pattern_length_q > LW'(PATTERN_MAX)) begin
      plen = LW'(PATTERN_MAX);
    end else begin
      plen = pattern_length_q;
    end
    if (replacement_length_q > LW'(REPLACE_MAX)) begin
      rlen = LW'(REPLACE_MAX);
    end else begin
      rlen = replacement_length_q;
    end
  end

  // control state
  state_e         state_q, state_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           match_done_q, match_done_d;
  logic [RIW-1:0] ridx_q, ridx_d;
  logic           pend_eot_q, pend_eot_d;

  // window row
  logic                      ins;
  logic                      shift;
  logic [sfr_pkg::CharW-1:0] post [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]    eq;
  logic [PATTERN_MAX-1:0]    care;
  logic                      match_all;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [sfr_pkg::CharW-1:0] right;
    if (i == PATTERN_MAX - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = post[i+1];
    end
    assign care[i] = (LW'(i) < plen);
    sfr_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (ins && (fill_q == FW'(i))),
      .shift_i (shift),
      .char_i  (text_char_i),
      .right_i (right),
      .pat_i   (pattern_bytes_q[sfr_pkg::CharW*i +: sfr_pkg::CharW]),
      .post_o  (post[i]),
      .eq_o    (eq[i])
    );
  end

  assign match_all = &(eq | ~care);

  // result path
  logic          push_v;
  sfr_pkg::res_t push_data;
  logic          skid_full;
  sfr_pkg::res_t out_data;
  logic          can_push;
  logic [FW-1:0] fill_inc;
  logic          repl_last;

  assign can_push   = !skid_full;
  assign in_stall_o = !((state_q == ST_RUN) && can_push);
  assign fill_inc   = fill_q + FW'(1);
  assign repl_last  = ((LW'(ridx_q) + LW'(1)) == rlen);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    match_done_d = match_done_q;
    ridx_d       = ridx_q;
    pend_eot_d   = pend_eot_q;
    push_v       = 1'b0;
    push_data    = '0;
    ins          = 1'b0;
    shift        = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && can_push) begin
          if (match_done_q) begin
            push_v            = 1'b1;
            push_data.ch      = text_char_i;
            push_data.present = 1'b1;
            push_data.last    = end_of_text_i;
            if (end_of_text_i) begin
              match_done_d = 1'b0;
            end
          end else begin
            ins = 1'b1;
            if ((LW'(fill_inc) == plen) && match_all) begin
              fill_d       = '0;
              match_done_d = 1'b1;
              if (rlen == '0) begin
                if (end_of_text_i) begin
                  // match deleted at the very end: end-only marker
                  push_v         = 1'b1;
                  push_data.last = 1'b1;
                  match_done_d   = 1'b0;
                end
              end else begin
                push_v            = 1'b1;
                push_data.ch      = replacement_bytes_q[sfr_pkg::CharW-1:0];
                push_data.present = 1'b1;
                if (rlen == LW'(1)) begin
                  push_data.last = end_of_text_i;
                  if (end_of_text_i) begin
                    match_done_d = 1'b0;
                  end
                end else begin
                  ridx_d     = RIW'(1);
                  pend_eot_d = end_of_text_i;
                  state_d    = ST_REPL;
                end
              end
            end else if (end_of_text_i || (LW'(fill_inc) >= plen)) begin
              push_v            = 1'b1;
              push_data.ch      = post[0];
              push_data.present = 1'b1;
              shift             = 1'b1;
              fill_d            = fill_q;
              if (end_of_text_i) begin
                if (fill_q == '0) begin
                  push_data.last = 1'b1;
                end else begin
                  state_d = ST_FLUSH;
                end
              end
            end else begin
              fill_d = fill_inc;
            end
          end
        end
      end
      ST_REPL: begin
        if (can_push) begin
          push_v            = 1'b1;
          push_data.ch      = replacement_bytes_q[sfr_pkg::CharW*ridx_q +: sfr_pkg::CharW];
          push_data.present = 1'b1;
          push_data.last    = repl_last && pend_eot_q;
          if (repl_last) begin
            state_d = ST_RUN;
            if (pend_eot_q) begin
              match_done_d = 1'b0;
            end
          end else begin
            ridx_d = ridx_q + RIW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push_v            = 1'b1;
          push_data.ch      = post[0];
          push_data.present = 1'b1;
          shift             = 1'b1;
          fill_d            = fill_q - FW'(1);
          if (fill_q == FW'(1)) begin
            push_data.last = 1'b1;
            state_d        = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      fill_q       <= '0;
      match_done_q <= 1'b0;
      ridx_q       <= '0;
      pend_eot_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      match_done_q <= match_done_d;
      ridx_q       <= ridx_d;
      pend_eot_q   <= pend_eot_d;
    end
  end

  sfr_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_v),
    .push_data_i (push_data),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign out_char_o      = out_data.ch;
  assign char_present_o  = out_data.present;
  assign end_of_output_o = out_data.last;

  `SFR_ASSERT_IMPL(a_fill_bound, state_q == ST_RUN, fill_q < FW'(PATTERN_MAX), "window overfull")
  `SFR_ASSERT_IMPL(a_flush_nonempty, state_q == ST_FLUSH, fill_q != '0, "flush of empty window")
  `SFR_ASSERT_IMPL(a_done_empty, match_done_q, fill_q == '0, "window kept after match")
  `SFR_ASSERT_IMPL(a_push_room, push_v, !skid_full, "result pushed into full skid stage")
  `SFR_ASSERT_NEXT(a_end_clears, push_v && push_data.last, !match_done_q && fill_q == '0 && state_q == ST_RUN, "state not cleared at end of text")

endmodule
